// File: hw/rtl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared constants and types of the greedy box suppression core.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

   localparam int MAX_BOXES = 64;
   localparam int IDX_W     = $clog2(MAX_BOXES);
   localparam int CNT_W     = $clog2(MAX_BOXES + 1);
   localparam int COORD_W   = 12;
   localparam int AREA_W    = 24;
   localparam int SCORE_W   = 16;
   localparam int THR_W     = 16;
   localparam int INTER_W   = 2 * COORD_W;
   localparam int UNION_W   = AREA_W + 3;
   localparam int PROD_W    = THR_W + UNION_W - 1;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [AREA_W-1:0]  area;
      logic [COORD_W-1:0] bottom;
      logic [COORD_W-1:0] right;
      logic [COORD_W-1:0] top;
      logic [COORD_W-1:0] left;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

// File: hw/rtl/gbs_ram.sv
// ----------------------------------------------------------------------------
// gbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: hw/rtl/greedy_box_suppression_core.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression_core
// Greedy IoU non-maximum suppression over one set of up to 64 boxes.
// ----------------------------------------------------------------------------
// loading: an ordinary box is stored on start while idle; a set_end item keeps busy high
//   for one scan and suppression pass per kept box, the final result strobing as busy falls
// each pick: a score scan over the box RAM, then a pass of every stored box through
//   the shared overlap pipeline (one box per cycle, one RAM read port)
// throughput: one box per cycle while loading; results are one-cycle strobes, no stall
// reset: synchronous; clears the live mask, box count and state, threshold to 32768
`default_nettype none

module greedy_box_suppression_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [gbs_pkg::COORD_W-1:0] req_left_x,
   input  wire logic [gbs_pkg::COORD_W-1:0] req_top_y,
   input  wire logic [gbs_pkg::COORD_W-1:0] req_right_x,
   input  wire logic [gbs_pkg::COORD_W-1:0] req_bottom_y,
   input  wire logic [gbs_pkg::AREA_W-1:0]  req_box_area,
   input  wire logic [gbs_pkg::SCORE_W-1:0] req_box_score,
   input  wire logic                        req_set_end,
   output logic                             rsp_valid,
   output logic [gbs_pkg::IDX_W-1:0]        rsp_kept_index,
   output logic [gbs_pkg::COORD_W-1:0]      rsp_kept_left,
   output logic [gbs_pkg::COORD_W-1:0]      rsp_kept_top,
   output logic [gbs_pkg::COORD_W-1:0]      rsp_kept_right,
   output logic [gbs_pkg::COORD_W-1:0]      rsp_kept_bottom,
   output logic [gbs_pkg::SCORE_W-1:0]      rsp_kept_score,
   output logic                             rsp_final_kept,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [gbs_pkg::THR_W-1:0]   csr_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_SUPP = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [gbs_pkg::MAX_BOXES-1:0]  alive_ff, alive_in;
   logic [gbs_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [gbs_pkg::CNT_W-1:0]      addr_ff, addr_in;
   logic [gbs_pkg::THR_W-1:0]      thr_ff;

   logic                           rd_vld_ff, rd_vld_in;
   logic [gbs_pkg::IDX_W-1:0]      rd_idx_ff;
   gbs_pkg::entry_type             rd_data;

   logic                           found_ff, found_in;
   logic [gbs_pkg::IDX_W-1:0]      best_idx_ff, best_idx_in;
   gbs_pkg::entry_type             best_ff, best_in;

   // overlap pipeline
   logic                           s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [gbs_pkg::IDX_W-1:0]      s1_idx_ff, s2_idx_ff, s3_idx_ff;
   logic [gbs_pkg::COORD_W-1:0]    s1_w_ff, s1_h_ff;
   logic [gbs_pkg::AREA_W-1:0]     s1_area_ff, s2_area_ff;
   logic [gbs_pkg::INTER_W-1:0]    s2_inter_ff, s3_inter_ff;
   logic signed [gbs_pkg::UNION_W-1:0] s3_union_ff;

   logic [gbs_pkg::COORD_W-1:0]    w_val, h_val;
   logic signed [gbs_pkg::COORD_W:0] w_dif, h_dif;
   logic [gbs_pkg::COORD_W-1:0]    min_r, max_l, min_b, max_t;
   logic signed [gbs_pkg::UNION_W-1:0] union_val;
   logic [gbs_pkg::PROD_W-1:0]     rhs, lhs;
   logic                           kill;
   logic                           issuing, drained;

   logic                           ram_we;
   gbs_pkg::entry_type             wr_entry;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [gbs_pkg::IDX_W-1:0]      rsp_idx_ff, rsp_idx_in;
   gbs_pkg::entry_type             rsp_ff, rsp_in;
   logic                           rsp_final_ff, rsp_final_in;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign wr_entry.left   = req_left_x;
   assign wr_entry.top    = req_top_y;
   assign wr_entry.right  = req_right_x;
   assign wr_entry.bottom = req_bottom_y;
   assign wr_entry.area   = req_box_area;
   assign wr_entry.score  = req_box_score;
   assign ram_we = start && !busy && (count_ff < gbs_pkg::CNT_W'(gbs_pkg::MAX_BOXES));

   gbs_ram #(
      .WIDTH(gbs_pkg::ENTRY_W),
      .DEPTH(gbs_pkg::MAX_BOXES)
   ) u_box_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[gbs_pkg::IDX_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (addr_ff[gbs_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign issuing = (state_ff == ST_SCAN || state_ff == ST_SUPP) && (addr_ff < count_ff);

   // stage 1: overlap extents against the pick
   always_comb begin
      min_r = (rd_data.right  < best_ff.right)  ? rd_data.right  : best_ff.right;
      max_l = (rd_data.left   > best_ff.left)   ? rd_data.left   : best_ff.left;
      min_b = (rd_data.bottom < best_ff.bottom) ? rd_data.bottom : best_ff.bottom;
      max_t = (rd_data.top    > best_ff.top)    ? rd_data.top    : best_ff.top;
      w_dif = $signed({1'b0, min_r}) - $signed({1'b0, max_l});
      h_dif = $signed({1'b0, min_b}) - $signed({1'b0, max_t});
      w_val = w_dif[gbs_pkg::COORD_W] ? '0 : w_dif[gbs_pkg::COORD_W-1:0];
      h_val = h_dif[gbs_pkg::COORD_W] ? '0 : h_dif[gbs_pkg::COORD_W-1:0];
   end

   // stage 3: union
   assign union_val = $signed({3'b000, s2_area_ff}) + $signed({3'b000, best_ff.area})
                    - $signed({3'b000, s2_inter_ff});

   // stage 4: inter * 2^16 > thr * union
   assign rhs  = gbs_pkg::PROD_W'(thr_ff) *
                 gbs_pkg::PROD_W'(s3_union_ff[gbs_pkg::UNION_W-2:0]);
   assign lhs  = gbs_pkg::PROD_W'({s3_inter_ff, 16'h0000});
   assign kill = s3_vld_ff && !s3_union_ff[gbs_pkg::UNION_W-1] && (lhs > rhs);

   assign drained = !issuing && !rd_vld_ff && !s1_vld_ff && !s2_vld_ff && !s3_vld_ff;

   always_comb begin
      state_in     = state_ff;
      alive_in     = alive_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      rd_vld_in    = issuing;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_in      = best_ff;
      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_in       = rsp_ff;
      rsp_final_in = rsp_final_ff;
      if (issuing) begin
         addr_in = addr_ff + 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (ram_we) begin
                  alive_in[count_ff[gbs_pkg::IDX_W-1:0]] = 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (req_set_end) begin
                  state_in = ST_SCAN;
                  addr_in  = '0;
                  found_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff && alive_ff[rd_idx_ff] &&
                (!found_ff || rd_data.score >= best_ff.score)) begin
               found_in    = 1'b1;
               best_idx_in = rd_idx_ff;
               best_in     = rd_data;
            end
            if (!issuing && !rd_vld_ff) begin
               if (found_ff) begin
                  alive_in[best_idx_ff] = 1'b0;
                  state_in = ST_SUPP;
                  addr_in  = '0;
               end else begin
                  state_in = ST_IDLE;
                  alive_in = '0;
                  count_in = '0;
               end
            end
         end
         ST_SUPP: begin
            if (kill) begin
               alive_in[s3_idx_ff] = 1'b0;
            end
            if (drained) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = best_idx_ff;
               rsp_in       = best_ff;
               rsp_final_in = (alive_ff == '0);
               found_in     = 1'b0;
               addr_in      = '0;
               if (alive_ff == '0) begin
                  state_in = ST_IDLE;
                  count_in = '0;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         alive_ff     <= '0;
         count_ff     <= '0;
         addr_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         s1_vld_ff    <= 1'b0;
         s2_vld_ff    <= 1'b0;
         s3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= gbs_pkg::THR_W'(32768);
      end else begin
         state_ff     <= state_in;
         alive_ff     <= alive_in;
         count_ff     <= count_in;
         addr_ff      <= addr_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         s1_vld_ff    <= rd_vld_ff && (state_ff == ST_SUPP);
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            thr_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= addr_ff[gbs_pkg::IDX_W-1:0];
      best_idx_ff  <= best_idx_in;
      best_ff      <= best_in;
      s1_idx_ff    <= rd_idx_ff;
      s1_w_ff      <= w_val;
      s1_h_ff      <= h_val;
      s1_area_ff   <= rd_data.area;
      s2_idx_ff    <= s1_idx_ff;
      s2_area_ff   <= s1_area_ff;
      s2_inter_ff  <= gbs_pkg::INTER_W'(s1_w_ff) * gbs_pkg::INTER_W'(s1_h_ff);
      s3_idx_ff    <= s2_idx_ff;
      s3_inter_ff  <= s2_inter_ff;
      s3_union_ff  <= union_val;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_ff       <= rsp_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kept_index  = rsp_idx_ff;
   assign rsp_kept_left   = rsp_ff.left;
   assign rsp_kept_top    = rsp_ff.top;
   assign rsp_kept_right  = rsp_ff.right;
   assign rsp_kept_bottom = rsp_ff.bottom;
   assign rsp_kept_score  = rsp_ff.score;
   assign rsp_final_kept  = rsp_final_ff;

endmodule

`default_nettype wire

// File: hw/rtl/gbs_checker.sv
// ----------------------------------------------------------------------------
// gbs_checker
// Port-level checks of the greedy box suppression core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_set_end,
   input wire logic rsp_valid,
   input wire logic rsp_final_kept
);

   // an item without set_end yields no result
   a_no_rsp_on_plain: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_set_end) |=> !rsp_valid)
      else $error("result after a plain item");

   // results are never back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back to back results");

   // a non-final result leaves the block busy
   a_more_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_final_kept) |-> busy)
      else $error("idle before final result");

   // the final result ends the set
   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_final_kept) |-> !busy)
      else $error("busy after final result");

endmodule

bind greedy_box_suppression_core gbs_checker u_gbs_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_set_end    (req_set_end),
   .rsp_valid      (rsp_valid),
   .rsp_final_kept (rsp_final_kept)
);

`default_nettype wire
